// ----- hw/rtl/pal_pkg.sv -----
// pal_pkg: opcodes, status codes, sequencer states and fixed field widths
// for the positional array list; used by every module of the block
// no dependencies

package pal_pkg;

    // default number of entries the list can hold
    localparam int CAPACITY_DEF = 16;

    // fixed field widths of the transfer channels
    localparam int OPCODE_W   = 3;
    localparam int POSITION_W = 5;
    localparam int VALUE_W    = 32;
    localparam int STATUS_W   = 2;
    localparam int COUNT_W    = 5;

    // opcodes
    localparam logic [OPCODE_W-1:0] OP_INSERT   = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_DELETE   = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_CLEAR    = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_TRAVERSE = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_PEEK     = 3'd4;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

    // sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_INS,
        S_INS_END,
        S_PUT,
        S_DEL,
        S_DEL_END,
        S_TRAV_RD,
        S_TRAV,
        S_RESP
    } pal_state_t;

endpackage

// ----- hw/rtl/positional_array_list.sv -----
// positional_array_list: top level, ordered list engine with a small
// sequencer that moves one entry per cycle through the entry memory,
// unless a low m_ready pauses a traverse; depends on pal_pkg and pal_mem
//
//   channel   direction   ports                                        transfer when
//   s_        in          s_opcode s_position s_value                  s_valid & s_ready
//   m_        out         m_data m_status m_count m_is_empty           m_valid & m_ready
//                         m_is_full m_last
//
// sequencer states after an accepted transfer: insert that shifts runs
//   S_INS (one read/write step per moved entry), S_INS_END, S_PUT, S_RESP;
//   append S_PUT, S_RESP; delete that shifts S_DEL, S_DEL_END, S_RESP;
//   traverse and peek S_TRAV_RD, then S_TRAV per entry; all else S_RESP.
//   the single memory port pair sets the one-entry-per-cycle pace
// reset: aresetn low clears the entry count, the sequencer and m_valid;
//   the entries themselves are never cleared, only written entries are read
// stalls: s_ready is high only while the sequencer is idle; m_ready held low
//   pauses traverse on the current entry, and the output register lets the
//   next transfer be accepted while the last result still waits

module positional_array_list #(
    parameter int CAPACITY = pal_pkg::CAPACITY_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [pal_pkg::OPCODE_W-1:0]   s_opcode,
    input  logic [pal_pkg::POSITION_W-1:0] s_position,
    input  logic signed [pal_pkg::VALUE_W-1:0] s_value,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic signed [pal_pkg::VALUE_W-1:0] m_data,
    output logic [pal_pkg::STATUS_W-1:0]   m_status,
    output logic [pal_pkg::COUNT_W-1:0]    m_count,
    output logic                           m_is_empty,
    output logic                           m_is_full,
    output logic                           m_last
);

    // address, count and compare widths
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = (CW > pal_pkg::POSITION_W) ? CW : pal_pkg::POSITION_W;

    pal_pkg::pal_state_t state_reg, state_next;

    // list state
    logic [CW-1:0] count_reg;

    // sequencer registers
    logic [AW-1:0] idx_reg;      // current read address
    logic [AW-1:0] tgt_reg;      // address at which the sweep stops
    logic [AW-1:0] wa_reg;       // write address of the entry read last cycle
    logic          pend_reg;     // a read is waiting to be written back
    logic [pal_pkg::VALUE_W-1:0]  value_reg;
    logic [pal_pkg::STATUS_W-1:0] st_reg;

    // output register
    logic                          m_valid_reg;
    logic [pal_pkg::VALUE_W-1:0]   m_data_reg;
    logic [pal_pkg::STATUS_W-1:0]  m_status_reg;
    logic [pal_pkg::COUNT_W-1:0]   m_count_reg;
    logic                          m_is_empty_reg;
    logic                          m_is_full_reg;
    logic                          m_last_reg;

    // memory port
    logic                         mem_we;
    logic [AW-1:0]                mem_waddr;
    logic [pal_pkg::VALUE_W-1:0]  mem_wdata;
    logic                         mem_re;
    logic [AW-1:0]                mem_raddr;
    logic [pal_pkg::VALUE_W-1:0]  mem_rdata;

    // decode of an incoming transfer
    pal_pkg::pal_state_t          dec_state;
    logic [pal_pkg::STATUS_W-1:0] dec_status;
    logic [AW-1:0]                dec_idx;
    logic [AW-1:0]                dec_tgt;
    logic [CW-1:0]                dec_count;
    logic [PW-1:0]                pos_e;
    logic [PW-1:0]                pos1_e;
    logic [PW-1:0]                cnt_e;
    logic                         list_empty;
    logic                         list_full;

    // output control
    logic                         out_free;
    logic                         load_out;
    logic [pal_pkg::VALUE_W-1:0]  out_data;
    logic                         out_last;
    logic [pal_pkg::STATUS_W-1:0] out_status;
    logic                         trav_last;

    assign out_free   = !m_valid_reg || m_ready;
    assign list_empty = (count_reg == '0);
    assign list_full  = (count_reg == CW'(CAPACITY));
    assign trav_last  = (idx_reg == tgt_reg);

    pal_mem #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // opcode decode against the current count
    always_comb begin
        pos_e      = PW'(s_position);
        cnt_e      = PW'(count_reg);
        pos1_e     = (pos_e == '0) ? PW'(1) : pos_e;   // position zero means the front
        dec_state  = pal_pkg::S_RESP;
        dec_status = pal_pkg::ST_OK;
        dec_idx    = '0;
        dec_tgt    = AW'(count_reg - CW'(1));
        dec_count  = count_reg;
        unique case (s_opcode)
            pal_pkg::OP_INSERT: begin
                if (list_full) begin
                    dec_status = pal_pkg::ST_FULL;
                end else if (pos1_e > cnt_e) begin
                    // append after the last entry
                    dec_state = pal_pkg::S_PUT;
                    dec_idx   = AW'(count_reg);
                end else begin
                    // shift entries up from the end down to the position
                    dec_state = pal_pkg::S_INS;
                    dec_idx   = AW'(count_reg - CW'(1));
                    dec_tgt   = AW'(pos1_e - PW'(1));
                end
            end
            pal_pkg::OP_DELETE: begin
                if (list_empty) begin
                    dec_status = pal_pkg::ST_EMPTY;
                end else if (pos_e == '0 || pos_e > cnt_e) begin
                    dec_status = pal_pkg::ST_RANGE;
                end else if (pos_e == cnt_e) begin
                    // last entry goes, nothing to move
                    dec_count = count_reg - CW'(1);
                end else begin
                    dec_state = pal_pkg::S_DEL;
                    dec_idx   = AW'(pos_e);
                end
            end
            pal_pkg::OP_CLEAR: begin
                dec_count = '0;
            end
            pal_pkg::OP_TRAVERSE: begin
                if (list_empty) begin
                    dec_status = pal_pkg::ST_EMPTY;
                end else begin
                    dec_state = pal_pkg::S_TRAV_RD;
                    dec_idx   = '0;
                end
            end
            pal_pkg::OP_PEEK: begin
                // a one-entry traverse of the last entry
                if (list_empty) begin
                    dec_status = pal_pkg::ST_EMPTY;
                end else begin
                    dec_state = pal_pkg::S_TRAV_RD;
                    dec_idx   = AW'(count_reg - CW'(1));
                end
            end
            default: begin
                dec_status = pal_pkg::ST_OK;
            end
        endcase
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            pal_pkg::S_IDLE: begin
                if (s_valid) state_next = dec_state;
            end
            pal_pkg::S_INS: begin
                if (idx_reg == tgt_reg) state_next = pal_pkg::S_INS_END;
            end
            pal_pkg::S_INS_END: state_next = pal_pkg::S_PUT;
            pal_pkg::S_PUT:     state_next = pal_pkg::S_RESP;
            pal_pkg::S_DEL: begin
                if (idx_reg == tgt_reg) state_next = pal_pkg::S_DEL_END;
            end
            pal_pkg::S_DEL_END: state_next = pal_pkg::S_RESP;
            pal_pkg::S_TRAV_RD: state_next = pal_pkg::S_TRAV;
            pal_pkg::S_TRAV: begin
                if (out_free && trav_last) state_next = pal_pkg::S_IDLE;
            end
            pal_pkg::S_RESP: begin
                if (out_free) state_next = pal_pkg::S_IDLE;
            end
            default: state_next = pal_pkg::S_IDLE;
        endcase
    end

    // memory and output controls
    always_comb begin
        s_ready    = 1'b0;
        mem_we     = 1'b0;
        mem_waddr  = wa_reg;
        mem_wdata  = mem_rdata;
        mem_re     = 1'b0;
        mem_raddr  = idx_reg;
        load_out   = 1'b0;
        out_data   = '0;
        out_last   = 1'b1;
        out_status = st_reg;
        unique case (state_reg)
            pal_pkg::S_IDLE: s_ready = 1'b1;
            pal_pkg::S_INS, pal_pkg::S_DEL: begin
                // read one entry, write back the one read the cycle before
                mem_re = 1'b1;
                mem_we = pend_reg;
            end
            pal_pkg::S_INS_END, pal_pkg::S_DEL_END: begin
                mem_we = 1'b1;
            end
            pal_pkg::S_PUT: begin
                mem_we    = 1'b1;
                mem_waddr = idx_reg;
                mem_wdata = value_reg;
            end
            pal_pkg::S_TRAV_RD: begin
                mem_re = 1'b1;
            end
            pal_pkg::S_TRAV: begin
                load_out   = out_free;
                out_data   = mem_rdata;
                out_last   = trav_last;
                out_status = pal_pkg::ST_OK;
                // fetch the next entry as this one leaves
                mem_re     = out_free && !trav_last;
                mem_raddr  = idx_reg + AW'(1);
            end
            pal_pkg::S_RESP: begin
                load_out = out_free;
            end
            default: s_ready = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= pal_pkg::S_IDLE;
            count_reg   <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;

            // output register
            if (load_out) begin
                m_valid_reg    <= 1'b1;
                m_data_reg     <= out_data;
                m_status_reg   <= out_status;
                m_count_reg    <= pal_pkg::COUNT_W'(count_reg);
                m_is_empty_reg <= list_empty;
                m_is_full_reg  <= list_full;
                m_last_reg     <= out_last;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                pal_pkg::S_IDLE: begin
                    if (s_valid) begin
                        value_reg <= s_value;
                        idx_reg   <= dec_idx;
                        tgt_reg   <= dec_tgt;
                        st_reg    <= dec_status;
                        count_reg <= dec_count;
                        pend_reg  <= 1'b0;
                    end
                end
                pal_pkg::S_INS: begin
                    pend_reg <= 1'b1;
                    wa_reg   <= idx_reg + AW'(1);
                    if (idx_reg != tgt_reg) idx_reg <= idx_reg - AW'(1);
                end
                pal_pkg::S_PUT: begin
                    count_reg <= count_reg + CW'(1);
                end
                pal_pkg::S_DEL: begin
                    pend_reg <= 1'b1;
                    wa_reg   <= idx_reg - AW'(1);
                    if (idx_reg != tgt_reg) idx_reg <= idx_reg + AW'(1);
                end
                pal_pkg::S_DEL_END: begin
                    count_reg <= count_reg - CW'(1);
                end
                pal_pkg::S_TRAV: begin
                    if (out_free) idx_reg <= idx_reg + AW'(1);
                end
                default: begin
                    pend_reg <= pend_reg;
                end
            endcase
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_data     = m_data_reg;
    assign m_status   = m_status_reg;
    assign m_count    = m_count_reg;
    assign m_is_empty = m_is_empty_reg;
    assign m_is_full  = m_is_full_reg;
    assign m_last     = m_last_reg;

endmodule

// ----- hw/rtl/pal_mem.sv -----
// pal_mem: entry storage of the list, one write and one read port,
// registered read data that holds while no read is issued
// depends on pal_pkg for the entry width and the default depth

module pal_mem #(
    parameter int DEPTH = pal_pkg::CAPACITY_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                        aclk,
    input  logic                        we,
    input  logic [AW-1:0]               waddr,
    input  logic [pal_pkg::VALUE_W-1:0] wdata,
    input  logic                        re,
    input  logic [AW-1:0]               raddr,
    output logic [pal_pkg::VALUE_W-1:0] rdata
);

    logic [pal_pkg::VALUE_W-1:0] mem [DEPTH];
    logic [pal_pkg::VALUE_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- test/tb.sv -----
// tb: self-checking bench for the positional array list engine
// drives insert, delete, clear, traverse, peek and query transfers and checks
// every result against a list model or a row's answer; depends on pal_pkg

module tb;

    import pal_pkg::*;

    // list size under test and run shape
    localparam int CAP          = CAPACITY_DEF;
    localparam int NUM_PROBES   = 22;
    localparam int RAND_ITEMS   = 80;
    localparam int TAIL_ITEMS   = 20;
    localparam int LONG_HOLD    = 300;
    localparam int HOLD_AFTER   = 40;
    localparam int DRAIN_CYCLES = 40;
    localparam int MAX_REPORTS  = 40;
    // far past the slowest legal run
    localparam int TIME_LIMIT   = 4000000;

    // opcodes the package leaves unnamed: five queries, six and seven act alike
    localparam logic [OPCODE_W-1:0] OP_QUERY  = 3'd5;
    localparam logic [OPCODE_W-1:0] OP_SPARE6 = 3'd6;
    localparam logic [OPCODE_W-1:0] OP_SPARE7 = 3'd7;

    // one result transfer as the block should present it
    typedef struct packed {
        logic [VALUE_W-1:0]  data;
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0]  count;
        logic                is_empty;
        logic                is_full;
        logic                last;
    } list_result_t;

    // one directed row; when known is set the expected status and count are
    // written into the row and data is zero
    typedef struct packed {
        logic [OPCODE_W-1:0]   op;
        logic [POSITION_W-1:0] pos;
        logic [VALUE_W-1:0]    val;
        logic                  known;
        logic [STATUS_W-1:0]   st;
        logic [COUNT_W-1:0]    cnt;
    } probe_row_t;

    // random part drifts between filling, mixing and draining the list
    typedef enum logic [1:0] {PH_GROW, PH_MIX, PH_SHRINK} drift_t;

    // dut ports, all inputs known from time zero
    logic                   aclk       = 1'b0;
    logic                   aresetn    = 1'b0;
    logic                   s_valid    = 1'b0;
    logic                   s_ready;
    logic [OPCODE_W-1:0]    s_opcode   = '0;
    logic [POSITION_W-1:0]  s_position = '0;
    logic signed [VALUE_W-1:0] s_value = '0;
    logic                   m_valid;
    logic                   m_ready    = 1'b0;
    logic signed [VALUE_W-1:0] m_data;
    logic [STATUS_W-1:0]    m_status;
    logic [COUNT_W-1:0]     m_count;
    logic                   m_is_empty;
    logic                   m_is_full;
    logic                   m_last;

    // list model: entries and fill level
    logic signed [VALUE_W-1:0] list_mem [CAP];
    int                        list_len = 0;

    // results still owed by the block, oldest first
    list_result_t pending_results [$];
    list_result_t head;

    int   fail_count   = 0;
    int   results_seen = 0;
    // set for the final stretch of items, where neither side idles
    logic calm_tail    = 1'b0;

    probe_row_t probe_rows [NUM_PROBES];

    positional_array_list #(
        .CAPACITY(CAP)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_opcode  (s_opcode),
        .s_position(s_position),
        .s_value   (s_value),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .m_status  (m_status),
        .m_count   (m_count),
        .m_is_empty(m_is_empty),
        .m_is_full (m_is_full),
        .m_last    (m_last)
    );

    always #10 aclk = ~aclk;

    // queue one result, flags taken from the list after the operation
    function automatic void owe_result(input logic [VALUE_W-1:0] data,
                                       input logic [STATUS_W-1:0] status,
                                       input logic last);
        list_result_t r;
        r.data     = data;
        r.status   = status;
        r.count    = list_len[COUNT_W-1:0];
        r.is_empty = (list_len == 0);
        r.is_full  = (list_len >= CAP);
        r.last     = last;
        pending_results.push_back(r);
    endfunction

    // apply one accepted transfer to the list model and queue its results
    function automatic void apply_list_op(input logic [OPCODE_W-1:0] op,
                                          input logic [POSITION_W-1:0] pos,
                                          input logic signed [VALUE_W-1:0] val);
        int p;
        case (op)
            OP_INSERT: begin
                if (list_len >= CAP) begin
                    owe_result('0, ST_FULL, 1'b1);
                end else begin
                    // position zero means the front, past the end appends
                    p = (pos == 0) ? 1 : int'(pos);
                    if (p > list_len) begin
                        list_mem[list_len] = val;
                    end else begin
                        for (int i = list_len; i >= p; i--)
                            list_mem[i] = list_mem[i-1];
                        list_mem[p-1] = val;
                    end
                    list_len++;
                    owe_result('0, ST_OK, 1'b1);
                end
            end
            OP_DELETE: begin
                if (list_len == 0) begin
                    owe_result('0, ST_EMPTY, 1'b1);
                end else if (pos == 0 || int'(pos) > list_len) begin
                    // out of range leaves the list alone
                    owe_result('0, ST_RANGE, 1'b1);
                end else begin
                    for (int i = int'(pos); i < list_len; i++)
                        list_mem[i-1] = list_mem[i];
                    list_len--;
                    owe_result('0, ST_OK, 1'b1);
                end
            end
            OP_CLEAR: begin
                list_len = 0;
                owe_result('0, ST_OK, 1'b1);
            end
            OP_TRAVERSE: begin
                if (list_len == 0) begin
                    owe_result('0, ST_EMPTY, 1'b1);
                end else begin
                    for (int i = 0; i < list_len; i++)
                        owe_result(list_mem[i], ST_OK, i == list_len - 1);
                end
            end
            OP_PEEK: begin
                if (list_len == 0)
                    owe_result('0, ST_EMPTY, 1'b1);
                else
                    owe_result(list_mem[list_len-1], ST_OK, 1'b1);
            end
            default: begin
                // query and the two spare opcodes just report the list
                owe_result('0, ST_OK, 1'b1);
            end
        endcase
    endfunction

    // one line per mismatch, printing stops after a while but counting goes on
    task automatic flag_mismatch(input string what, input logic [VALUE_W-1:0] got,
                                 input logic [VALUE_W-1:0] want);
        if (fail_count < MAX_REPORTS)
            $display("tb: mismatch on %s: got %h, want %h", what, got, want);
        fail_count++;
    endtask

    // offer one transfer on the input side, wait for it to be taken, then
    // account for it in the list model
    task automatic offer_item(input probe_row_t row);
        list_result_t typed_res;
        list_result_t dropped;
        // random idle burst ahead of the item, none in the calm tail
        if (!calm_tail && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_opcode   <= row.op;
        s_position <= row.pos;
        s_value    <= row.val;
        do @(posedge aclk); while (!s_ready);
        apply_list_op(row.op, row.pos, row.val);
        if (row.known) begin
            // the row carries its own answer, use it in place of the model's
            dropped            = pending_results.pop_back();
            typed_res.data     = '0;
            typed_res.status   = row.st;
            typed_res.count    = row.cnt;
            typed_res.is_empty = (row.cnt == 0);
            typed_res.is_full  = (row.cnt == CAP);
            typed_res.last     = 1'b1;
            pending_results.push_back(typed_res);
        end
    endtask

    // stimulus: reset, directed table, drifting random part, drain, verdict
    initial begin
        probe_row_t     row;
        drift_t         phase;
        int             mix_left;
        int             brim_hits;
        int             roll;
        logic [OPCODE_W-1:0] op;

        probe_rows = '{
            // empty list: query, then every read-type op must say empty
            '{OP_QUERY,    5'd0,  32'h0000_0000, 1'b1, ST_OK,    5'd0},
            '{OP_PEEK,     5'd0,  32'hFFFF_FFFF, 1'b1, ST_EMPTY, 5'd0},
            '{OP_TRAVERSE, 5'd31, 32'h0000_0000, 1'b1, ST_EMPTY, 5'd0},
            '{OP_DELETE,   5'd1,  32'h0000_0000, 1'b1, ST_EMPTY, 5'd0},
            '{OP_CLEAR,    5'd0,  32'h0000_0000, 1'b1, ST_OK,    5'd0},
            // position ignored on an empty list
            '{OP_INSERT,   5'd5,  32'h7FFF_FFFF, 1'b1, ST_OK,    5'd1},
            // position zero lands at the front
            '{OP_INSERT,   5'd0,  32'h8000_0000, 1'b1, ST_OK,    5'd2},
            // far past the end appends
            '{OP_INSERT,   5'd31, 32'hFFFF_FFFF, 1'b1, ST_OK,    5'd3},
            '{OP_INSERT,   5'd2,  32'h0000_0000, 1'b0, ST_OK,    5'd0},
            '{OP_INSERT,   5'd16, 32'hA5A5_A5A5, 1'b0, ST_OK,    5'd0},
            '{OP_PEEK,     5'd0,  32'h0000_0000, 1'b0, ST_OK,    5'd0},
            '{OP_TRAVERSE, 5'd0,  32'h0000_0000, 1'b0, ST_OK,    5'd0},
            // out-of-range deletes keep all five entries
            '{OP_DELETE,   5'd0,  32'h0000_0000, 1'b1, ST_RANGE, 5'd5},
            '{OP_DELETE,   5'd6,  32'h0000_0000, 1'b1, ST_RANGE, 5'd5},
            '{OP_DELETE,   5'd31, 32'hFFFF_FFFF, 1'b1, ST_RANGE, 5'd5},
            '{OP_DELETE,   5'd5,  32'h0000_0000, 1'b0, ST_OK,    5'd0},
            '{OP_DELETE,   5'd1,  32'h0000_0000, 1'b0, ST_OK,    5'd0},
            // spare opcodes behave as a query
            '{OP_SPARE6,   5'd3,  32'h1234_5678, 1'b1, ST_OK,    5'd3},
            '{OP_SPARE7,   5'd31, 32'hFFFF_FFFF, 1'b1, ST_OK,    5'd3},
            '{OP_TRAVERSE, 5'd0,  32'h0000_0000, 1'b0, ST_OK,    5'd0},
            '{OP_CLEAR,    5'd7,  32'h0000_0000, 1'b1, ST_OK,    5'd0},
            '{OP_TRAVERSE, 5'd16, 32'h0000_0000, 1'b1, ST_EMPTY, 5'd0}
        };

        // synchronous reset, released before the directed table starts
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int k = 0; k < NUM_PROBES; k++)
            offer_item(probe_rows[k]);

        // random part: grow to full and beat on it, mix, shrink to empty, repeat
        phase     = PH_GROW;
        mix_left  = 0;
        brim_hits = 0;
        for (int n = 0; n < RAND_ITEMS; n++) begin
            calm_tail = (n >= RAND_ITEMS - TAIL_ITEMS);
            roll      = $urandom_range(0, 15);
            op        = OPCODE_W'($urandom_range(0, 7));
            case (phase)
                PH_GROW: begin
                    if (roll < 12)
                        op = OP_INSERT;
                    else if (op == OP_CLEAR)
                        op = OP_PEEK;
                end
                PH_SHRINK: begin
                    if (roll < 11)
                        op = OP_DELETE;
                    else if (op == OP_CLEAR)
                        op = OP_TRAVERSE;
                end
                default: begin
                    // clears stay rare while mixing
                    if (op == OP_CLEAR && roll != 0)
                        op = OP_TRAVERSE;
                end
            endcase

            row.op    = op;
            row.val   = $urandom;
            row.known = 1'b0;
            row.st    = ST_OK;
            row.cnt   = '0;
            // mostly legal positions, now and then anything the field holds
            if ($urandom_range(0, 5) == 0)
                row.pos = POSITION_W'($urandom_range(0, 31));
            else if (op == OP_DELETE)
                row.pos = POSITION_W'($urandom_range(1, (list_len > 0) ? list_len : 1));
            else
                row.pos = POSITION_W'($urandom_range(0, list_len + 1));

            offer_item(row);

            case (phase)
                PH_GROW: begin
                    if (list_len == CAP)
                        brim_hits++;
                    if (brim_hits >= 3) begin
                        phase     = PH_MIX;
                        mix_left  = 12;
                        brim_hits = 0;
                    end
                end
                PH_MIX: begin
                    mix_left--;
                    if (mix_left <= 0)
                        phase = PH_SHRINK;
                end
                default: begin
                    if (list_len == 0)
                        brim_hits++;
                    if (brim_hits >= 2) begin
                        phase     = PH_GROW;
                        brim_hits = 0;
                    end
                end
            endcase
        end
        s_valid <= 1'b0;

        // drain what is still owed, then give the block time to misbehave
        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // result side ready: short random stalls, one long hold-off that lets
    // the block back up and drop s_ready, no stalls in the calm tail
    initial begin
        logic long_done;
        long_done = 1'b0;
        @(posedge aclk);
        while (!aresetn)
            @(posedge aclk);
        forever begin
            @(posedge aclk);
            if (!long_done && results_seen >= HOLD_AFTER) begin
                long_done = 1'b1;
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                m_ready <= 1'b1;
            end else if (!calm_tail && $urandom_range(0, 7) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge aclk);
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // result checker: every accepted result against the oldest owed one
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                flag_mismatch("unexpected result, data", m_data, '0);
            end else begin
                head = pending_results.pop_front();
                if (m_data !== head.data)
                    flag_mismatch("data", m_data, head.data);
                if (m_status !== head.status)
                    flag_mismatch("status", 32'(m_status), 32'(head.status));
                if (m_count !== head.count)
                    flag_mismatch("count", 32'(m_count), 32'(head.count));
                if (m_is_empty !== head.is_empty)
                    flag_mismatch("is_empty", 32'(m_is_empty), 32'(head.is_empty));
                if (m_is_full !== head.is_full)
                    flag_mismatch("is_full", 32'(m_is_full), 32'(head.is_full));
                if (m_last !== head.last)
                    flag_mismatch("last", 32'(m_last), 32'(head.last));
            end
        end
    end

    // hang guard
    initial begin
        #(TIME_LIMIT);
        $display("tb: failure");
        $finish;
    end

endmodule
